FILE: design/mbrx_pkg.sv
// ----------------------------------------------------------------------------
// mbrx_pkg
// Shared types, constants and the CRC-16 byte step for the Modbus RTU
// slave frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrx_pkg;

  localparam int BUF_DEPTH = 128;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W     = 9;

  localparam logic [2:0] FUNC_BYTE  = 3'd0;
  localparam logic [2:0] FUNC_TICK  = 3'd1;
  localparam logic [2:0] FUNC_CHECK = 3'd2;
  localparam logic [2:0] FUNC_CLEAR = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ADDR = 2'd1;
  localparam logic [1:0] ST_CRC  = 2'd2;

  localparam logic [7:0]  LEN_SHORT     = 8'd6;
  localparam logic [7:0]  FUNC_LONG_MIN = 8'd7;
  localparam logic [7:0]  LEN_BYTE_POS  = 8'd6;
  localparam logic [7:0]  GAP_MAX       = 8'd255;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  localparam logic [7:0] STATION_RESET = 8'd1;
  localparam logic [7:0] GAP_RESET     = 8'd10;

  localparam logic [0:0] REG_STATION = 1'b0;
  localparam logic [0:0] REG_GAP     = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_FILL  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_FUNC,
    S_LEN,
    S_CRC,
    S_LO,
    S_HI
  } state_t;

  typedef enum logic [2:0] {
    RA_IN,
    RA_ZERO,
    RA_ONE,
    RA_SIX,
    RA_PTR_NEXT,
    RA_LEN1
  } ra_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } item_t;

  typedef struct packed {
    logic       frame_ready;
    logic [1:0] check_status;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic       exec;
    logic       rd_en;
    ra_t        ra;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       len_short;
    logic       len_long;
    logic       crc_init;
    logic       crc_step;
    logic       lo_store;
    logic       finish;
    logic       is_read;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic addr_match;
    logic func_short;
    logic overlen;
    logic crc_last;
    logic crc_ok;
  } stat_t;

  // One byte through the reflected CRC-16, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/mbrx_dp.sv
// ----------------------------------------------------------------------------
// mbrx_dp
// Datapath: frame buffer, receive phase, gap counter, length and CRC
// registers, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrx_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mbrx_pkg::item_t  item,
  input  wire mbrx_pkg::cmd_t   cmd,
  input  wire logic [7:0]       station,
  input  wire logic [7:0]       gap_limit,
  output mbrx_pkg::stat_t       stat,
  output mbrx_pkg::result_t     result
);

  localparam int IW = mbrx_pkg::IDX_W;
  localparam int LW = mbrx_pkg::LEN_W;

  logic [7:0]          mem [mbrx_pkg::BUF_DEPTH];
  logic                valid [mbrx_pkg::BUF_DEPTH];
  logic [7:0]          mem_q;
  logic                vld_q;
  logic [7:0]          rdata;

  mbrx_pkg::phase_t    phase;
  logic [IW-1:0]       widx;
  logic [7:0]          gap;
  logic [7:0]          gap_inc;
  logic [IW-1:0]       ptr;
  logic [IW-1:0]       len;
  logic [LW-1:0]       len_sum;
  logic [15:0]         crc;
  logic                lo_ok;
  logic [1:0]          status_q;
  logic                rd_flag;

  logic [IW-1:0]       raddr;
  logic                raddr_ok;
  logic                do_write;

  always_comb begin
    raddr_ok = 1'b1;
    unique case (cmd.ra)
      mbrx_pkg::RA_IN: begin
        raddr    = IW'(item.read_index);
        raddr_ok = {2'b00, item.read_index} < LW'(mbrx_pkg::BUF_DEPTH);
      end
      mbrx_pkg::RA_ZERO:     raddr = '0;
      mbrx_pkg::RA_ONE:      raddr = IW'(1);
      mbrx_pkg::RA_SIX:      raddr = IW'(mbrx_pkg::LEN_BYTE_POS);
      mbrx_pkg::RA_PTR_NEXT: raddr = ptr + 1'b1;
      mbrx_pkg::RA_LEN1:     raddr = len + 1'b1;
      default:               raddr = '0;
    endcase
  end

  assign do_write = cmd.exec && item.func == mbrx_pkg::FUNC_BYTE &&
                    phase != mbrx_pkg::PH_READY;

  // buffer storage and registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[widx] <= item.rx_byte;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mbrx_pkg::BUF_DEPTH; i++) begin
        valid[i] <= 1'b0;
      end
      vld_q <= 1'b0;
    end else begin
      if (do_write) begin
        valid[widx] <= 1'b1;
      end
      if (cmd.rd_en) begin
        vld_q <= valid[raddr] && raddr_ok;
      end
    end
  end

  // never-written slots read as zero
  assign rdata = vld_q ? mem_q : 8'h00;

  assign gap_inc = (gap < mbrx_pkg::GAP_MAX) ? gap + 8'd1 : gap;

  // receive phase, write index, gap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mbrx_pkg::PH_WAIT;
      widx  <= '0;
      gap   <= '0;
    end else if (cmd.exec) begin
      unique case (item.func)
        mbrx_pkg::FUNC_BYTE: begin
          if (phase != mbrx_pkg::PH_READY) begin
            phase <= mbrx_pkg::PH_FILL;
            gap   <= '0;
            if (widx != IW'(mbrx_pkg::BUF_DEPTH - 1)) begin
              widx <= widx + 1'b1;
            end
          end
        end
        mbrx_pkg::FUNC_TICK: begin
          if (phase == mbrx_pkg::PH_FILL) begin
            gap <= gap_inc;
            if (gap_inc > gap_limit) begin
              widx  <= '0;
              phase <= mbrx_pkg::PH_READY;
            end
          end
        end
        mbrx_pkg::FUNC_CLEAR: phase <= mbrx_pkg::PH_WAIT;
        default: ;
      endcase
    end
  end

  assign len_sum = {1'b0, rdata} + LW'(mbrx_pkg::LEN_SHORT);

  // check walk registers
  always_ff @(posedge clk) begin
    if (cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + 1'b1;
    end
    if (cmd.len_short) begin
      len <= IW'(mbrx_pkg::LEN_SHORT);
    end else if (cmd.len_long) begin
      len <= IW'(len_sum);
    end
    if (cmd.crc_init) begin
      crc <= mbrx_pkg::CRC_INIT;
    end else if (cmd.crc_step) begin
      crc <= mbrx_pkg::crc_byte(crc, rdata);
    end
    if (cmd.lo_store) begin
      lo_ok <= rdata == crc[7:0];
    end
    if (cmd.finish) begin
      status_q <= cmd.status;
      rd_flag  <= cmd.is_read;
    end
  end

  assign stat.addr_match = rdata == station;
  assign stat.func_short = rdata < mbrx_pkg::FUNC_LONG_MIN;
  assign stat.overlen    = len_sum >= LW'(mbrx_pkg::BUF_DEPTH - 1);
  assign stat.crc_last   = (ptr + 1'b1) == len;
  assign stat.crc_ok     = lo_ok && rdata == crc[15:8];

  assign result.frame_ready  = phase == mbrx_pkg::PH_READY;
  assign result.check_status = status_q;
  assign result.read_data    = rd_flag ? rdata : 8'h00;

endmodule

`default_nettype wire

FILE: design/mbrx_ctrl.sv
// ----------------------------------------------------------------------------
// mbrx_ctrl
// Controller: takes commands and sequences the frame check through the
// single buffer read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrx_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [2:0]      func,
  input  wire mbrx_pkg::stat_t stat,
  output mbrx_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 done
);

  mbrx_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbrx_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = state != mbrx_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.ra     = mbrx_pkg::RA_IN;
    cmd.status = mbrx_pkg::ST_OK;
    unique case (state)
      mbrx_pkg::S_IDLE: begin
        if (start) begin
          if (func == mbrx_pkg::FUNC_CHECK) begin
            cmd.rd_en  = 1'b1;
            cmd.ra     = mbrx_pkg::RA_ZERO;
            state_next = mbrx_pkg::S_ADDR;
          end else begin
            cmd.exec    = 1'b1;
            cmd.finish  = 1'b1;
            cmd.is_read = func == mbrx_pkg::FUNC_READ;
            cmd.rd_en   = func == mbrx_pkg::FUNC_READ;
          end
        end
      end
      mbrx_pkg::S_ADDR: begin
        if (!stat.addr_match) begin
          cmd.finish = 1'b1;
          cmd.status = mbrx_pkg::ST_ADDR;
          state_next = mbrx_pkg::S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra     = mbrx_pkg::RA_ONE;
          state_next = mbrx_pkg::S_FUNC;
        end
      end
      mbrx_pkg::S_FUNC: begin
        cmd.rd_en = 1'b1;
        if (stat.func_short) begin
          cmd.ra        = mbrx_pkg::RA_ZERO;
          cmd.len_short = 1'b1;
          cmd.crc_init  = 1'b1;
          cmd.ptr_clr   = 1'b1;
          state_next    = mbrx_pkg::S_CRC;
        end else begin
          cmd.ra     = mbrx_pkg::RA_SIX;
          state_next = mbrx_pkg::S_LEN;
        end
      end
      mbrx_pkg::S_LEN: begin
        if (stat.overlen) begin
          cmd.finish = 1'b1;
          cmd.status = mbrx_pkg::ST_CRC;
          state_next = mbrx_pkg::S_IDLE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.ra       = mbrx_pkg::RA_ZERO;
          cmd.len_long = 1'b1;
          cmd.crc_init = 1'b1;
          cmd.ptr_clr  = 1'b1;
          state_next   = mbrx_pkg::S_CRC;
        end
      end
      mbrx_pkg::S_CRC: begin
        // next address is ptr+1, which is the CRC low byte on the last pass
        cmd.rd_en    = 1'b1;
        cmd.ra       = mbrx_pkg::RA_PTR_NEXT;
        cmd.crc_step = 1'b1;
        cmd.ptr_inc  = 1'b1;
        if (stat.crc_last) begin
          state_next = mbrx_pkg::S_LO;
        end
      end
      mbrx_pkg::S_LO: begin
        cmd.lo_store = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.ra       = mbrx_pkg::RA_LEN1;
        state_next   = mbrx_pkg::S_HI;
      end
      mbrx_pkg::S_HI: begin
        cmd.finish = 1'b1;
        cmd.status = stat.crc_ok ? mbrx_pkg::ST_OK : mbrx_pkg::ST_CRC;
        state_next = mbrx_pkg::S_IDLE;
      end
      default: state_next = mbrx_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/modbus_rtu_slave_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_receiver_core
// Modbus RTU slave receive side: frame buffer, silent-gap timing and
// address / CRC-16 frame check.
// ----------------------------------------------------------------------------
// Usage:
//  - A command beat is taken when start is high and busy is low. item.func
//    selects: byte received, timer tick, check frame, clear ready, read.
//  - Each command gives exactly one result beat, shown on result for one
//    cycle with done high. The receiver cannot stall, so it must take it.
//  - Byte, tick, clear, read and unused codes: result in the cycle after the
//    command; busy stays low, so a new command may follow every cycle.
//  - Check frame: busy until done. An address mismatch answers once
//    byte 0 is read, an overlength frame once byte 6 is read; a full check
//    walks the buffer one byte a cycle through its single read port and a
//    byte-wide CRC step over len bytes, then compares the two CRC bytes,
//    len being 6 (short function codes, byte 6 not read) or byte 6 + 6.
//  - Registers station_address (0x0) and gap_limit (0x4) on the APB port,
//    to be written only while the block is idle (not enforced by the block).
//  - Reset (rst, synchronous) clears phase, write index, gap count and the
//    buffer valid bits at once; unwritten slots read as zero, so no
//    clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_slave_frame_receiver_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire mbrx_pkg::item_t   item,
  output logic                   busy,
  output logic                   done,
  output mbrx_pkg::result_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [7:0]      station;
  logic [7:0]      gap_limit;
  logic            cfg_wr;
  mbrx_pkg::cmd_t  cmd;
  mbrx_pkg::stat_t stat;

  // configuration registers; register select is the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      station   <= mbrx_pkg::STATION_RESET;
      gap_limit <= mbrx_pkg::GAP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mbrx_pkg::REG_STATION: station   <= pwdata[7:0];
        mbrx_pkg::REG_GAP:     gap_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign prdata = {24'h000000, (paddr[2] == mbrx_pkg::REG_GAP) ? gap_limit : station};

  mbrx_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (item.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mbrx_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .station   (station),
    .gap_limit (gap_limit),
    .stat      (stat),
    .result    (result)
  );

  // an accepted beat either answers next cycle or starts a check
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("accepted beat neither answered nor started a check");

  // the phase never moves while a check walks the buffer
  a_ready_stable: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(result.frame_ready))
    else $error("frame_ready moved during a check");

  // buffer data is only shown for a read, which answers straight from idle
  a_read_from_idle: assert property (@(posedge clk) disable iff (rst)
    done && result.read_data != 8'h00 |->
      !$past(busy) && result.check_status == mbrx_pkg::ST_OK)
    else $error("read data shown outside a read result");

  // status code three is never produced
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.check_status != 2'd3)
    else $error("undefined check status");

endmodule

`default_nettype wire
